// File: rtl/core/pit_pkg.sv
// Shared constants and types for the primitive intersection tester.
// No dependencies; the interfaces and the top level use it by scoped names.
package pit_pkg;

  // Width of one signed fixed-point coordinate. The fraction point never moves
  // because every test compares values of equal scale.
  localparam int COORD_BITS = 20;
  localparam int OPCODE_BITS = 3;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_BOX_BOX       = OPCODE_BITS'(0),
    OP_BOX_POINT     = OPCODE_BITS'(1),
    OP_BOX_SPHERE    = OPCODE_BITS'(2),
    OP_SPHERE_SPHERE = OPCODE_BITS'(3),
    OP_SEGMENT_BOX   = OPCODE_BITS'(4)
  } opcode_t;

endpackage

// File: rtl/core/pit_ifs.sv
// Valid/ready channel interfaces for the primitive intersection tester.
// Depends on pit_pkg for the coordinate and opcode widths.
interface pit_in_if #(
  parameter int COORD_BITS = pit_pkg::COORD_BITS
) ();
  logic                               valid;
  logic                               ready;
  logic [pit_pkg::OPCODE_BITS-1:0]    opcode;
  logic [3*COORD_BITS-1:0]            first_center;
  logic [3*COORD_BITS-1:0]            first_size;
  logic [3*COORD_BITS-1:0]            second_center;
  logic [3*COORD_BITS-1:0]            second_size;

  modport source (
    output valid, opcode, first_center, first_size, second_center, second_size,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_center, first_size, second_center, second_size,
    output ready
  );
endinterface

interface pit_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// File: rtl/core/primitive_intersection_tester_top.sv
// Top level of the primitive intersection tester: a four-stage pipeline.
// Depends on pit_pkg and on the pit_in_if / pit_out_if interfaces.
// Takes one primitive pair per cycle while nothing stalls and returns one hit
// bit for each pair, in order. A word passes through the stage 1, 2 and 3
// registers and then the output register; the multipliers (cross products and
// squares) each get a register stage of their own. Each stage holds its word
// until the next one frees up, so the input keeps accepting while any stage
// ahead of it is empty, and while a result waits to be taken the output
// register takes no new word.
// Opcodes 0 to 4 select box-box, box-point (x and y only), box-sphere,
// sphere-sphere and segment-box; other opcodes give a miss.
module primitive_intersection_tester_top #(
  parameter int COORD_BITS = pit_pkg::COORD_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  pit_in_if.sink     in_ch,
  pit_out_if.source  out_ch
);

  localparam int C  = COORD_BITS;
  localparam int D1 = C + 1;           // difference of two coordinates
  localparam int D2 = C + 2;           // three-term sums, segment midpoint
  localparam int D3 = C + 3;           // extent plus length, epsilon-padded length
  localparam int SQ1 = 2 * D1;         // square of a D1 value
  localparam int SQ2 = 2 * D2;         // square of a D2 value
  localparam int P  = D2 + D1;         // midpoint times direction
  localparam int Q  = 2 * C + 4;       // cross difference, extent products, sums
  localparam int Q2 = 2 * C + 6;       // sum of three D2 squares

  // ---------------------------------------------------------------- handshake
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out = !out_valid_r || out_ch.ready;
  assign rdy3    = !v3_r || rdy_out;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;

  assign in_ch.ready  = rdy1;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_ch.valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  // ------------------------------------------------- stage 1: linear terms
  logic signed [C-1:0]  fc [3];
  logic signed [C-1:0]  fs [3];
  logic signed [C-1:0]  sc [3];
  logic signed [C-1:0]  ss [3];

  logic signed [D1-1:0] s1_cd_nxt [3];
  logic signed [D1-1:0] s1_es_nxt [3];
  logic signed [D2-1:0] s1_nd_nxt [3];
  logic signed [D2-1:0] s1_pd_nxt [3];
  logic signed [D2-1:0] s1_m_nxt  [3];
  logic signed [D1-1:0] s1_dd_nxt [3];
  logic signed [D1-1:0] s1_e2_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fc[i] = signed'(in_ch.first_center[i*C +: C]);
      fs[i] = signed'(in_ch.first_size[i*C +: C]);
      sc[i] = signed'(in_ch.second_center[i*C +: C]);
      ss[i] = signed'(in_ch.second_size[i*C +: C]);
      // Center difference, reused by box-box and sphere-sphere.
      s1_cd_nxt[i] = D1'(fc[i]) - D1'(sc[i]);
      s1_es_nxt[i] = D1'(fs[i]) + D1'(ss[i]);
      // Box-sphere with d = sphere - box: nd = -e - d, pd = e - d.
      s1_nd_nxt[i] = D2'(fc[i]) - D2'(sc[i]) - D2'(fs[i]);
      s1_pd_nxt[i] = D2'(fc[i]) - D2'(sc[i]) + D2'(fs[i]);
      // Segment: doubled midpoint relative to the box, full direction, doubled extent.
      s1_m_nxt[i]  = D2'(fc[i]) + D2'(fs[i]) - D2'(sc[i]) - D2'(sc[i]);
      s1_dd_nxt[i] = D1'(fs[i]) - D1'(fc[i]);
      s1_e2_nxt[i] = signed'({ss[i], 1'b0});
    end
  end

  logic [pit_pkg::OPCODE_BITS-1:0] s1_op_r;
  logic signed [D1-1:0] s1_cd_r [3];
  logic signed [D1-1:0] s1_es_r [3];
  logic signed [D2-1:0] s1_nd_r [3];
  logic signed [D2-1:0] s1_pd_r [3];
  logic signed [D2-1:0] s1_m_r  [3];
  logic signed [D1-1:0] s1_dd_r [3];
  logic signed [D1-1:0] s1_e2_r [3];
  logic signed [D1-1:0] s1_rs_r;
  logic signed [C-1:0]  s1_rad_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_op_r  <= in_ch.opcode;
      s1_cd_r  <= s1_cd_nxt;
      s1_es_r  <= s1_es_nxt;
      s1_nd_r  <= s1_nd_nxt;
      s1_pd_r  <= s1_pd_nxt;
      s1_m_r   <= s1_m_nxt;
      s1_dd_r  <= s1_dd_nxt;
      s1_e2_r  <= s1_e2_nxt;
      s1_rs_r  <= D1'(fs[0]) + D1'(ss[0]);
      s1_rad_r <= ss[0];
    end
  end

  // -------------------------------- stage 2: compares, clamps, first products
  logic                  s2_bb_nxt;
  logic                  s2_bp_nxt;
  logic                  s2_segax_nxt;
  logic signed [D2-1:0]  s2_diff_nxt [3];
  logic signed [D2-1:0]  bs_lo       [3];
  logic signed [SQ1-1:0] s2_sq_nxt   [3];
  logic [D1-1:0]         ad          [3];
  logic [D2-1:0]         am          [3];
  logic [D2-1:0]         s2_ad1_nxt  [3];
  logic signed [P-1:0]   s2_cpa_nxt  [3];
  logic signed [P-1:0]   s2_cpb_nxt  [3];

  always_comb begin
    s2_bb_nxt    = 1'b1;
    s2_segax_nxt = 1'b1;
    // Box-point: -e < p - c < e is pd > 0 and nd < 0, on x and y only.
    s2_bp_nxt = (s1_pd_r[0] > D2'(0)) && (s1_nd_r[0] < D2'(0)) &&
                (s1_pd_r[1] > D2'(0)) && (s1_nd_r[1] < D2'(0));
    for (int i = 0; i < 3; i++) begin
      if ((D2'(s1_cd_r[i]) < -D2'(s1_es_r[i])) || (D2'(s1_cd_r[i]) > D2'(s1_es_r[i]))) begin
        s2_bb_nxt = 1'b0;
      end
      // Clamped offset minus offset is min(max(0, nd), pd).
      bs_lo[i]       = (s1_nd_r[i] > D2'(0)) ? s1_nd_r[i] : D2'(0);
      s2_diff_nxt[i] = (bs_lo[i] > s1_pd_r[i]) ? s1_pd_r[i] : bs_lo[i];
      s2_sq_nxt[i]   = SQ1'(s1_cd_r[i]) * SQ1'(s1_cd_r[i]);
      ad[i] = s1_dd_r[i][D1-1] ? D1'(-s1_dd_r[i]) : D1'(s1_dd_r[i]);
      am[i] = s1_m_r[i][D2-1]  ? D2'(-s1_m_r[i])  : D2'(s1_m_r[i]);
      if (signed'(D3'(am[i])) > (D3'(s1_e2_r[i]) + signed'(D3'(ad[i])))) begin
        s2_segax_nxt = 1'b0;
      end
      // One LSB of the doubled scale stands in for the epsilon.
      s2_ad1_nxt[i] = D2'(ad[i]) + D2'(1);
    end
    for (int a = 0; a < 3; a++) begin
      s2_cpa_nxt[a] = P'(s1_m_r[(a+1)%3]) * P'(s1_dd_r[(a+2)%3]);
      s2_cpb_nxt[a] = P'(s1_m_r[(a+2)%3]) * P'(s1_dd_r[(a+1)%3]);
    end
  end

  logic [pit_pkg::OPCODE_BITS-1:0] s2_op_r;
  logic                  s2_bb_r;
  logic                  s2_bp_r;
  logic signed [D2-1:0]  s2_diff_r [3];
  logic signed [2*C-1:0] s2_rsq_r;
  logic                  s2_rpos_r;
  logic signed [SQ1-1:0] s2_sq_r   [3];
  logic signed [SQ1-1:0] s2_rssq_r;
  logic                  s2_rspos_r;
  logic                  s2_segax_r;
  logic signed [P-1:0]   s2_cpa_r  [3];
  logic signed [P-1:0]   s2_cpb_r  [3];
  logic signed [D1-1:0]  s2_e2_r   [3];
  logic [D2-1:0]         s2_ad1_r  [3];

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_op_r    <= s1_op_r;
      s2_bb_r    <= s2_bb_nxt;
      s2_bp_r    <= s2_bp_nxt;
      s2_diff_r  <= s2_diff_nxt;
      s2_rsq_r   <= (2*C)'(s1_rad_r) * (2*C)'(s1_rad_r);
      s2_rpos_r  <= s1_rad_r > C'(0);
      s2_sq_r    <= s2_sq_nxt;
      s2_rssq_r  <= SQ1'(s1_rs_r) * SQ1'(s1_rs_r);
      s2_rspos_r <= s1_rs_r > D1'(0);
      s2_segax_r <= s2_segax_nxt;
      s2_cpa_r   <= s2_cpa_nxt;
      s2_cpb_r   <= s2_cpb_nxt;
      s2_e2_r    <= s1_e2_r;
      s2_ad1_r   <= s2_ad1_nxt;
    end
  end

  // --------------------------- stage 3: second products, sphere-sphere sum
  logic signed [SQ2-1:0] s3_bsq_nxt   [3];
  logic signed [Q-1:0]   s3_cross_nxt [3];
  logic signed [Q-1:0]   s3_qa_nxt    [3];
  logic signed [Q-1:0]   s3_qb_nxt    [3];
  logic signed [Q-1:0]   ss_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_bsq_nxt[i] = SQ2'(s2_diff_r[i]) * SQ2'(s2_diff_r[i]);
    end
    for (int a = 0; a < 3; a++) begin
      s3_cross_nxt[a] = Q'(s2_cpa_r[a]) - Q'(s2_cpb_r[a]);
      s3_qa_nxt[a] = Q'(s2_e2_r[(a+1)%3]) * Q'(signed'({1'b0, s2_ad1_r[(a+2)%3]}));
      s3_qb_nxt[a] = Q'(s2_e2_r[(a+2)%3]) * Q'(signed'({1'b0, s2_ad1_r[(a+1)%3]}));
    end
    ss_sum = Q'(s2_sq_r[0]) + Q'(s2_sq_r[1]) + Q'(s2_sq_r[2]);
  end

  logic [pit_pkg::OPCODE_BITS-1:0] s3_op_r;
  logic                  s3_bb_r;
  logic                  s3_bp_r;
  logic signed [SQ2-1:0] s3_bsq_r   [3];
  logic signed [2*C-1:0] s3_rsq_r;
  logic                  s3_rpos_r;
  logic                  s3_ss_r;
  logic                  s3_segax_r;
  logic signed [Q-1:0]   s3_cross_r [3];
  logic signed [Q-1:0]   s3_qa_r    [3];
  logic signed [Q-1:0]   s3_qb_r    [3];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_op_r    <= s2_op_r;
      s3_bb_r    <= s2_bb_r;
      s3_bp_r    <= s2_bp_r;
      s3_bsq_r   <= s3_bsq_nxt;
      s3_rsq_r   <= s2_rsq_r;
      s3_rpos_r  <= s2_rpos_r;
      s3_ss_r    <= s2_rspos_r && (ss_sum < Q'(s2_rssq_r));
      s3_segax_r <= s2_segax_r;
      s3_cross_r <= s3_cross_nxt;
      s3_qa_r    <= s3_qa_nxt;
      s3_qb_r    <= s3_qb_nxt;
    end
  end

  // ------------------------------- stage 4: final compares and opcode select
  logic signed [Q2-1:0] bs_sum;
  logic                 bs_ok;
  logic                 seg_ok;
  logic [Q-1:0]         cross_abs [3];
  logic                 hit_nxt;
  logic                 hit_r;

  always_comb begin
    bs_sum = Q2'(s3_bsq_r[0]) + Q2'(s3_bsq_r[1]) + Q2'(s3_bsq_r[2]);
    bs_ok  = s3_rpos_r && (bs_sum < Q2'(s3_rsq_r));
    seg_ok = s3_segax_r;
    for (int a = 0; a < 3; a++) begin
      cross_abs[a] = s3_cross_r[a][Q-1] ? Q'(-s3_cross_r[a]) : Q'(s3_cross_r[a]);
      if (signed'(Q2'(cross_abs[a])) > (Q2'(s3_qa_r[a]) + Q2'(s3_qb_r[a]))) begin
        seg_ok = 1'b0;
      end
    end
    case (s3_op_r)
      pit_pkg::OP_BOX_BOX:       hit_nxt = s3_bb_r;
      pit_pkg::OP_BOX_POINT:     hit_nxt = s3_bp_r;
      pit_pkg::OP_BOX_SPHERE:    hit_nxt = bs_ok;
      pit_pkg::OP_SPHERE_SPHERE: hit_nxt = s3_ss_r;
      pit_pkg::OP_SEGMENT_BOX:   hit_nxt = seg_ok;
      default:                   hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_ch.hit = hit_r;

  // --------------------------------------------------------------- checks
  // An accepted word always lands in the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted word did not enter stage 1");

  // With every stage full and the output stalled, the input must push back.
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && v3_r && v2_r && v1_r |-> !in_ch.ready)
    else $error("input accepted while the pipeline was full and stalled");

  // A word in the last stage moves to the output register when it is free.
  a_last_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && rdy_out |=> out_valid_r)
    else $error("word in stage 3 was lost on its way to the output");

  // Reset empties the output register and the first stage.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !v1_r)
    else $error("reset did not clear the pipeline valid bits");

endmodule
